>>> rtl/core/tdpf_pkg.sv
// ----------------------------------------------------------------------------
// tdpf_pkg
// Shared widths, defaults and types of the timed duplicate packet filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpf_pkg;

   localparam int KEY_W           = 64;
   localparam int TIME_W          = 32;
   localparam int ENTRIES_DEFAULT = 16;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30000;

   // one cache slot as stored in the entry memory
   typedef struct packed {
      logic [KEY_W-1:0]  key_high;
      logic [KEY_W-1:0]  key_low;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   // what the scan controller hands back at the end of an item
   typedef struct packed {
      logic done;
      logic is_duplicate;
   } scan_result_type;

endpackage

`default_nettype wire

>>> rtl/core/tdpf_req_if.sv
// ----------------------------------------------------------------------------
// tdpf_req_if
// Request channel: one packet key and the current millisecond time per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdpf_req_if;
   logic                            valid;
   logic                            ready;
   logic [tdpf_pkg::KEY_W-1:0]      key_high;
   logic [tdpf_pkg::KEY_W-1:0]      key_low;
   logic [tdpf_pkg::TIME_W-1:0]     now_ms;

   modport source (output valid, output key_high, output key_low, output now_ms,
                   input ready);
   modport sink   (input valid, input key_high, input key_low, input now_ms,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/core/tdpf_rsp_if.sv
// ----------------------------------------------------------------------------
// tdpf_rsp_if
// Response channel: one duplicate flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdpf_rsp_if;
   logic valid;
   logic ready;
   logic is_duplicate;

   modport source (output valid, output is_duplicate, input ready);
   modport sink   (input valid, input is_duplicate, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tdpf_entry_ram.sv
// ----------------------------------------------------------------------------
// tdpf_entry_ram
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpf_entry_ram #(
   parameter int ENTRIES = tdpf_pkg::ENTRIES_DEFAULT,
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic                clock,
   input  wire logic                rd_en,
   input  wire logic [IDX_W-1:0]    rd_addr,
   output tdpf_pkg::entry_type      rd_data,
   input  wire logic                wr_en,
   input  wire logic [IDX_W-1:0]    wr_addr,
   input  wire tdpf_pkg::entry_type wr_data
);

   tdpf_pkg::entry_type mem [ENTRIES];
   tdpf_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/tdpf_scan_ctrl.sv
// ----------------------------------------------------------------------------
// tdpf_scan_ctrl
// Walks the entry memory once per item: expires old slots, looks for the key,
// then inserts it at the ring pointer on a miss. Holds the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpf_scan_ctrl #(
   parameter int ENTRIES = tdpf_pkg::ENTRIES_DEFAULT,
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          out_free,
   input  wire logic [tdpf_pkg::KEY_W-1:0]    key_high,
   input  wire logic [tdpf_pkg::KEY_W-1:0]    key_low,
   input  wire logic [tdpf_pkg::TIME_W-1:0]   now_ms,
   input  wire logic [tdpf_pkg::TIME_W-1:0]   timeout_ms,
   output logic                               idle,
   output tdpf_pkg::scan_result_type          result,
   output logic                               rd_en,
   output logic [IDX_W-1:0]                   rd_addr,
   input  wire tdpf_pkg::entry_type           rd_data,
   output logic                               wr_en,
   output logic [IDX_W-1:0]                   wr_addr,
   output tdpf_pkg::entry_type                wr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_LAST  = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [1:0]               state_ff, state_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]         cmp_idx_ff;
   logic                     cmp_vld_ff;
   logic                     hit_ff, hit_in;
   logic [IDX_W-1:0]         ptr_ff, ptr_in;
   logic [ENTRIES-1:0]       valid_ff, valid_in;

   logic [tdpf_pkg::TIME_W-1:0] age;
   logic                        slot_valid;
   logic                        expired;
   logic                        key_match;
   logic                        insert;

   // compare stage works on the entry read in the previous cycle
   assign age        = now_ms - rd_data.stamp;
   assign expired    = age > timeout_ms;
   assign key_match  = (rd_data.key_high == key_high) && (rd_data.key_low == key_low);
   assign slot_valid = valid_ff[cmp_idx_ff];

   assign insert = (state_ff == ST_WRITE) && out_free && !hit_ff;

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      hit_in      = hit_ff;
      ptr_in      = ptr_ff;
      valid_in    = valid_ff;

      if (cmp_vld_ff && slot_valid) begin
         if (expired) begin
            valid_in[cmp_idx_ff] = 1'b0;
         end else if (key_match) begin
            hit_in = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
               hit_in      = 1'b0;
            end
         end
         ST_SCAN: begin
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (!hit_ff) begin
                  valid_in[ptr_ff] = 1'b1;
                  ptr_in = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         ptr_ff     <= '0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= (state_ff == ST_SCAN);
         hit_ff     <= hit_in;
         ptr_ff     <= ptr_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= scan_idx_ff;
   end

   assign idle    = (state_ff == ST_IDLE);
   assign rd_en   = (state_ff == ST_SCAN);
   assign rd_addr = scan_idx_ff;

   assign wr_en            = insert;
   assign wr_addr          = ptr_ff;
   assign wr_data.key_high = key_high;
   assign wr_data.key_low  = key_low;
   assign wr_data.stamp    = now_ms;

   assign result.done         = (state_ff == ST_WRITE) && out_free;
   assign result.is_duplicate = hit_ff;

endmodule

`default_nettype wire

>>> rtl/core/timed_duplicate_packet_filter_unit.sv
// ----------------------------------------------------------------------------
// timed_duplicate_packet_filter_unit
// Ring cache of recent packet keys with age-based expiry; flags duplicates.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  req     | in  | valid / ready   | key_high[63:0], key_low[63:0], now_ms[31:0]
//  rsp     | out | valid / ready   | is_duplicate
//  csr     | in  | csr_wr_en       | csr_wr_data[31:0] (timeout_ms)
//
//  an item: accept, one memory read per entry, compare drain, write-back
//  the entry memory read port sets the pace; one item is in the scan at a time
//  the response register frees the scan: a new beat is taken while a result waits
//  a result stalled on rsp holds the next item in its write-back cycle
//  reset clears valid bits, ring pointer and sets timeout_ms to 30000
// ----------------------------------------------------------------------------
`default_nettype none

module timed_duplicate_packet_filter_unit #(
   parameter int ENTRIES = tdpf_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tdpf_req_if.sink                           req,
   tdpf_rsp_if.source                         rsp,
   input  wire logic                          csr_wr_en,
   input  wire logic [tdpf_pkg::TIME_W-1:0]   csr_wr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [tdpf_pkg::KEY_W-1:0]  key_high_ff;
   logic [tdpf_pkg::KEY_W-1:0]  key_low_ff;
   logic [tdpf_pkg::TIME_W-1:0] now_ff;
   logic [tdpf_pkg::TIME_W-1:0] timeout_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_dup_ff;

   logic                        idle;
   logic                        req_beat;
   logic                        out_free;
   tdpf_pkg::scan_result_type   result;

   logic                        rd_en;
   logic [IDX_W-1:0]            rd_addr;
   tdpf_pkg::entry_type         rd_data;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   tdpf_pkg::entry_type         wr_data;

   assign req.ready = idle;
   assign req_beat  = req.valid && idle;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (req_beat) begin
         key_high_ff <= req.key_high;
         key_low_ff  <= req.key_low;
         now_ff      <= req.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= tdpf_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (result.done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.done) begin
         rsp_dup_ff <= result.is_duplicate;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.is_duplicate = rsp_dup_ff;

   tdpf_scan_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_scan_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (req_beat),
      .out_free   (out_free),
      .key_high   (key_high_ff),
      .key_low    (key_low_ff),
      .now_ms     (now_ff),
      .timeout_ms (timeout_ff),
      .idle       (idle),
      .result     (result),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   tdpf_entry_ram #(
      .ENTRIES (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

`default_nettype wire

>>> rtl/core/tdpf_checker.sv
// ----------------------------------------------------------------------------
// tdpf_checker
// Port-level checks of the duplicate filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_is_duplicate
);

   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] pending_ff, pending_in;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // and keeps its flag
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_is_duplicate))
      else $error("rsp payload changed while stalled");

   // the scan is still busy in the cycle after an accept
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("req accepted on the cycle after an accept");

   // no result without an item in flight
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("rsp beat with no outstanding req");

   // one item in the scan plus one waiting in the response register
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_ready)
      else $error("more than two items outstanding");

endmodule

bind timed_duplicate_packet_filter_unit tdpf_checker u_tdpf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_is_duplicate (rsp.is_duplicate)
);

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timed duplicate packet filter. A shadow copy of
// the key cache predicts each duplicate flag. Directed beats cover the key
// extremes, the exact-timeout age, wrapping and backward time and ring reuse.
// Random phases then run under several timeouts, from zero to all ones, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS         = tdpf_pkg::ENTRIES_DEFAULT;
   localparam int KW            = tdpf_pkg::KEY_W;
   localparam int TW            = tdpf_pkg::TIME_W;
   localparam int POOL_SIZE     = 20;
   localparam int PHASE_PKTS    = 64;
   localparam int SETTLE_CYCLES = 30;
   localparam int IDLE_LIMIT    = 4000;

   typedef struct {
      logic [KW-1:0] key_high;
      logic [KW-1:0] key_low;
      logic [TW-1:0] now_ms;
   } pkt_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [TW-1:0] csr_wr_data;

   tdpf_req_if req_if ();
   tdpf_rsp_if rsp_if ();

   timed_duplicate_packet_filter_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // shadow cache
   logic [KW-1:0] shadow_key_high [SLOTS];
   logic [KW-1:0] shadow_key_low  [SLOTS];
   logic [TW-1:0] shadow_stamp    [SLOTS];
   logic          shadow_valid    [SLOTS];
   int unsigned   shadow_ptr;
   logic [TW-1:0] shadow_timeout;

   pkt_type       pending_pkts [$];
   logic          expected_dup_q [$];

   int unsigned   send_gap;
   int unsigned   stall_left;
   bit            send_steady;
   bit            sink_steady;
   int unsigned   idle_cycles;

   int unsigned   mismatch_count;
   int unsigned   pkts_accepted;
   int unsigned   dup_count;
   int unsigned   expire_count;
   int unsigned   timeout_writes;

   logic [TW-1:0] cur_ms;
   logic [KW-1:0] pool_high [POOL_SIZE];
   logic [KW-1:0] pool_low  [POOL_SIZE];

   // expire, look up, insert on a miss; returns the duplicate flag
   function automatic logic predict_duplicate(input pkt_type p);
      logic [TW-1:0] age;
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         age = p.now_ms - shadow_stamp[i];
         if (shadow_valid[i] && age > shadow_timeout) begin
            shadow_valid[i] = 1'b0;
            expire_count++;
         end
      end
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_key_high[i] == p.key_high &&
             shadow_key_low[i] == p.key_low)
            hit = 1'b1;
      if (!hit) begin
         shadow_key_high[shadow_ptr] = p.key_high;
         shadow_key_low[shadow_ptr]  = p.key_low;
         shadow_stamp[shadow_ptr]    = p.now_ms;
         shadow_valid[shadow_ptr]    = 1'b1;
         shadow_ptr = (shadow_ptr + 1) % SLOTS;
      end
      return hit;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 8);
      return $urandom_range(10, 40);
   endfunction

   function automatic pkt_type random_pkt(input logic [TW-1:0] tmo);
      pkt_type p;
      logic [TW-1:0] step;
      int unsigned r;
      int unsigned idx;
      r = $urandom_range(0, 99);
      if (r < 55)      step = $urandom_range(0, (tmo < 8) ? 2 : (tmo >> 2));
      else if (r < 62) step = tmo;
      else if (r < 69) step = tmo + 1;
      else if (r < 79) step = $urandom;
      else if (r < 85) step = 32'd0 - $urandom_range(1, 100);
      else             step = '0;
      cur_ms = cur_ms + step;
      p.now_ms = cur_ms;
      idx = $urandom_range(0, POOL_SIZE - 1);
      r = $urandom_range(0, 99);
      if (r < 70) begin
         p.key_high = pool_high[idx];
         p.key_low  = pool_low[idx];
      end else if (r < 85) begin
         // near miss: one bit away from a pool key
         p.key_high = pool_high[idx];
         p.key_low  = pool_low[idx];
         if ($urandom_range(0, 1))
            p.key_high = p.key_high ^ (64'd1 << $urandom_range(0, KW - 1));
         else
            p.key_low = p.key_low ^ (64'd1 << $urandom_range(0, KW - 1));
      end else begin
         p.key_high = {$urandom, $urandom};
         p.key_low  = {$urandom, $urandom};
      end
      return p;
   endfunction

   task automatic queue_pkt(input logic [KW-1:0] kh, input logic [KW-1:0] kl,
                            input logic [TW-1:0] t);
      pkt_type p;
      p.key_high = kh;
      p.key_low  = kl;
      p.now_ms   = t;
      pending_pkts.push_back(p);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_pkts.size() != 0 || req_if.valid || expected_dup_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TW-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      timeout_writes++;
   endtask

   // request driver
   always @(posedge clock) begin
      pkt_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap     <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_gap != 0) begin
            req_if.valid <= 1'b0;
            send_gap     <= send_gap - 1;
         end else if (pending_pkts.size() != 0) begin
            nxt = pending_pkts.pop_front();
            req_if.valid    <= 1'b1;
            req_if.key_high <= nxt.key_high;
            req_if.key_low  <= nxt.key_low;
            req_if.now_ms   <= nxt.now_ms;
            if (!send_steady && $urandom_range(0, 99) < 35)
               send_gap <= pick_gap();
            if ($urandom_range(0, 99) < 3)
               send_steady <= ~send_steady;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         if ($urandom_range(0, 99) < 3)
            sink_steady <= ~sink_steady;
         if (!sink_steady && $urandom_range(0, 99) < 25) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= pick_gap() - 1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      pkt_type seen;
      logic want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            shadow_valid[i]    = 1'b0;
            shadow_key_high[i] = '0;
            shadow_key_low[i]  = '0;
            shadow_stamp[i]    = '0;
         end
         shadow_ptr     = 0;
         shadow_timeout = tdpf_pkg::TIMEOUT_RESET;
      end else begin
         if (csr_wr_en)
            shadow_timeout = csr_wr_data;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_dup_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result beat with nothing pending, is_duplicate=%b",
                           $realtime, rsp_if.is_duplicate);
            end else begin
               want = expected_dup_q.pop_front();
               if (want) dup_count++;
               if (rsp_if.is_duplicate !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: is_duplicate mismatch, expected %b got %b",
                              $realtime, want, rsp_if.is_duplicate);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            seen.key_high = req_if.key_high;
            seen.key_low  = req_if.key_low;
            seen.now_ms   = req_if.now_ms;
            expected_dup_q.push_back(predict_duplicate(seen));
            pkts_accepted++;
         end
      end
   end

   // watchdog on beat-free cycles
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $realtime, IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [TW-1:0] timeouts [7];
      logic [KW-1:0] key_a;
      logic [KW-1:0] ones;

      clock           = 1'b0;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_if.valid    = 1'b0;
      req_if.key_high = '0;
      req_if.key_low  = '0;
      req_if.now_ms   = '0;
      rsp_if.ready    = 1'b0;
      send_steady     = 1'b0;
      sink_steady     = 1'b0;
      idle_cycles     = 0;
      mismatch_count  = 0;
      pkts_accepted   = 0;
      dup_count       = 0;
      expire_count    = 0;
      timeout_writes  = 0;
      ones            = '1;

      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_high[i] = {$urandom, $urandom};
         pool_low[i]  = {$urandom, $urandom};
      end
      pool_high[1] = pool_high[0] ^ (64'd1 << $urandom_range(0, KW - 1));
      pool_low[1]  = pool_low[0];
      pool_high[2] = pool_high[0];
      pool_low[2]  = pool_low[0] ^ (64'd1 << $urandom_range(0, KW - 1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed beats under the reset timeout of 30000
      key_a = {$urandom, $urandom};
      queue_pkt('0, '0, 32'd0);
      queue_pkt('0, '0, 32'd0);
      queue_pkt(ones, ones, 32'd10);
      queue_pkt(ones, '0, 32'd10);
      queue_pkt('0, ones, 32'd10);
      queue_pkt(64'd1 << (KW - 1), '0, 32'd10);
      queue_pkt('0, 64'd1, 32'd10);
      queue_pkt(ones, ones, 32'd10);
      queue_pkt('0, '0, 32'd30000);           // age equals timeout, still cached
      queue_pkt('0, '0, 32'd30001);           // one past, expired
      queue_pkt('0, '0, 32'd30000);           // time stepped back
      queue_pkt(ones, ones, 32'd30000);
      queue_pkt(key_a, ~key_a, 32'hFFFF_FFF0);
      queue_pkt(key_a, ~key_a, 32'h0000_0010); // age across the wrap
      queue_pkt(ones, ones, 32'hFFFF_FFFF);
      for (int i = 0; i < 8; i++)             // wrap the ring pointer past the last slot
         queue_pkt({$urandom, $urandom}, {$urandom, $urandom}, 32'h0000_0010);
      queue_pkt(key_a, ~key_a, 32'h0000_0010);
      wait_drained();

      timeouts = '{32'd0, 32'd1, 32'd7, 32'd1000, 32'hFFFF_FFFF,
                   tdpf_pkg::TIMEOUT_RESET, 32'd0};
      timeouts[6] = $urandom_range(2, 50000);
      cur_ms = 32'hFFFF_F000;
      foreach (timeouts[k]) begin
         write_timeout(timeouts[k]);
         for (int n = 0; n < PHASE_PKTS; n++)
            pending_pkts.push_back(random_pkt(timeouts[k]));
         wait_drained();
      end

      if (expected_dup_q.size() != 0) begin
         mismatch_count++;
         $display("%0d results never arrived", expected_dup_q.size());
      end
      $display("%0d packets checked, %0d duplicates, %0d cache expiries",
               pkts_accepted, dup_count, expire_count);
      $display("%0d timeout settings from zero to all ones, %0d mismatches",
               timeout_writes, mismatch_count);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
